@@ rtl/core/ktsc_pkg.sv @@
// Package for the knob time-setting controller.
// Holds the knob command codes, field select codes, field limits and the
// shared state types. It depends on nothing else.
package ktsc_pkg;

    // Knob command codes.
    localparam logic [1:0] CMD_FWD   = 2'd0;
    localparam logic [1:0] CMD_BACK  = 2'd1;
    localparam logic [1:0] CMD_PRESS = 2'd2;

    // Field select codes, in editing order.
    localparam logic [2:0] FIELD_YEAR   = 3'd0;
    localparam logic [2:0] FIELD_MONTH  = 3'd1;
    localparam logic [2:0] FIELD_DAY    = 3'd2;
    localparam logic [2:0] FIELD_HOUR   = 3'd3;
    localparam logic [2:0] FIELD_MINUTE = 3'd4;
    localparam logic [2:0] FIELD_SECOND = 3'd5;

    // Field limits.
    localparam logic [7:0] YEAR_MIN   = 8'd70;
    localparam logic [7:0] YEAR_MAX   = 8'd255;
    localparam logic [3:0] MONTH_MIN  = 4'd0;
    localparam logic [3:0] MONTH_MAX  = 4'd11;
    localparam logic [4:0] DAY_MIN    = 5'd1;
    localparam logic [4:0] DAY_MAX    = 5'd31;
    localparam logic [4:0] HOUR_MIN   = 5'd0;
    localparam logic [4:0] HOUR_MAX   = 5'd23;
    localparam logic [5:0] MINSEC_MIN = 6'd0;
    localparam logic [5:0] MINSEC_MAX = 6'd59;

    // One set of calendar and time fields.
    typedef struct packed {
        logic [7:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } clk_fields_t;

    // Controller state: mode, selected field and the held values.
    typedef struct packed {
        logic        setting;
        logic [2:0]  field;
        clk_fields_t vals;
    } ctl_state_t;

    localparam ctl_state_t ST_RESET = '{
        setting: 1'b0,
        field:   FIELD_YEAR,
        vals:    '{year: YEAR_MIN, month: MONTH_MIN, day: DAY_MIN,
                   hour: HOUR_MIN, minute: MINSEC_MIN, second: MINSEC_MIN}
    };

endpackage : ktsc_pkg

@@ rtl/core/ktsc_update.sv @@
// Next-state logic of the knob time-setting controller for one request.
// Purely combinational; depends on ktsc_pkg for codes, limits and types.
module ktsc_update (
    input  logic [1:0]              cmd,
    input  ktsc_pkg::clk_fields_t   rtc,
    input  ktsc_pkg::ctl_state_t    st,
    output ktsc_pkg::ctl_state_t    st_next,
    output logic                    commit
);
    import ktsc_pkg::*;

    logic        fwd;
    clk_fields_t stepped;

    assign fwd = (cmd == CMD_FWD);

    // Step the selected field by one, with clamp or wrap as the field requires.
    always_comb
    begin
        stepped = st.vals;
        unique case (st.field)
            FIELD_YEAR:
            begin
                if (fwd)
                    stepped.year = (st.vals.year >= YEAR_MAX) ? YEAR_MAX
                                                              : st.vals.year + 8'd1;
                else
                    stepped.year = (st.vals.year <= YEAR_MIN) ? YEAR_MIN
                                                              : st.vals.year - 8'd1;
            end
            FIELD_MONTH:
            begin
                if (fwd)
                    stepped.month = (st.vals.month >= MONTH_MAX) ? MONTH_MIN
                                                                 : st.vals.month + 4'd1;
                else
                    stepped.month = (st.vals.month <= MONTH_MIN) ? MONTH_MAX
                                                                 : st.vals.month - 4'd1;
            end
            FIELD_DAY:
            begin
                // A day of one or zero steps back to the last day.
                if (fwd)
                    stepped.day = (st.vals.day >= DAY_MAX) ? DAY_MIN
                                                           : st.vals.day + 5'd1;
                else
                    stepped.day = (st.vals.day <= DAY_MIN) ? DAY_MAX
                                                           : st.vals.day - 5'd1;
            end
            FIELD_HOUR:
            begin
                if (fwd)
                    stepped.hour = (st.vals.hour >= HOUR_MAX) ? HOUR_MIN
                                                              : st.vals.hour + 5'd1;
                else
                    stepped.hour = (st.vals.hour <= HOUR_MIN) ? HOUR_MAX
                                                              : st.vals.hour - 5'd1;
            end
            FIELD_MINUTE:
            begin
                if (fwd)
                    stepped.minute = (st.vals.minute >= MINSEC_MAX) ? MINSEC_MIN
                                                                    : st.vals.minute + 6'd1;
                else
                    stepped.minute = (st.vals.minute <= MINSEC_MIN) ? MINSEC_MAX
                                                                    : st.vals.minute - 6'd1;
            end
            FIELD_SECOND:
            begin
                if (fwd)
                    stepped.second = (st.vals.second >= MINSEC_MAX) ? MINSEC_MIN
                                                                    : st.vals.second + 6'd1;
                else
                    stepped.second = (st.vals.second <= MINSEC_MIN) ? MINSEC_MAX
                                                                    : st.vals.second - 6'd1;
            end
            default:
            begin
                stepped = st.vals;
            end
        endcase
    end

    // Decode the knob command and form the next state.
    always_comb
    begin
        st_next = st;
        commit  = 1'b0;
        unique case (cmd) inside
            CMD_FWD, CMD_BACK:
            begin
                // Turns only act in setting mode.
                if (st.setting)
                    st_next.vals = stepped;
            end
            CMD_PRESS:
            begin
                if (!st.setting)
                begin
                    // Enter setting mode with the current clock time.
                    st_next.vals    = rtc;
                    st_next.field   = FIELD_YEAR;
                    st_next.setting = 1'b1;
                end
                else if (st.field >= FIELD_SECOND)
                begin
                    // Leaving the last field writes the time back.
                    commit          = 1'b1;
                    st_next.setting = 1'b0;
                end
                else
                begin
                    st_next.field = st.field + 3'd1;
                end
            end
            default:
            begin
                st_next = st;
            end
        endcase
    end

endmodule : ktsc_update

@@ rtl/core/knob_time_setting_controller_top.sv @@
// Top level of the knob time-setting controller.
// Holds the request register, the controller state and the result register;
// instantiates ktsc_update and uses ktsc_pkg.

// Each knob request is held in the request register and then goes through
// the update logic into the result register. A new request is accepted in
// every cycle that in_stall is low, so the sustained rate is one request
// per clock unless stalled; the controller state is updated as a request
// moves from the request register to the result register, which keeps
// back-to-back requests in order. Every accepted request gives exactly
// one result showing the mode, the selected field and all held values
// after it, with commit high only on the press that leaves setting mode.
module knob_time_setting_controller_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [7:0] rtc_year,
    input  logic [3:0] rtc_month,
    input  logic [4:0] rtc_day,
    input  logic [4:0] rtc_hour,
    input  logic [5:0] rtc_minute,
    input  logic [5:0] rtc_second,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       in_setting,
    output logic [2:0] field_sel,
    output logic [7:0] set_year,
    output logic [3:0] set_month,
    output logic [4:0] set_day,
    output logic [4:0] set_hour,
    output logic [5:0] set_minute,
    output logic [5:0] set_second,
    output logic       commit
);
    import ktsc_pkg::*;

    logic        in_vld_reg, in_vld_next;
    logic [1:0]  cmd_reg;
    clk_fields_t rtc_reg;
    ctl_state_t  st_reg, st_next;
    logic        out_vld_reg, out_vld_next;
    ctl_state_t  res_reg;
    logic        commit_reg;
    logic        upd_commit;
    logic        advance;
    logic        accept;

    // Handshake: the request moves on when the result register is free.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign accept   = in_valid && !in_stall;

    ktsc_update u_update (
        .cmd     (cmd_reg),
        .rtc     (rtc_reg),
        .st      (st_reg),
        .st_next (st_next),
        .commit  (upd_commit)
    );

    // Valid flags of the two stages.
    always_comb
    begin
        in_vld_next = accept ? 1'b1 : (advance ? 1'b0 : in_vld_reg);
        if (advance)
            out_vld_next = 1'b1;
        else if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    // Control state and controller state, cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            st_reg      <= ST_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
                st_reg <= st_next;
        end
    end

    // Request payload register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
            rtc_reg <= '{year: rtc_year, month: rtc_month, day: rtc_day,
                         hour: rtc_hour, minute: rtc_minute, second: rtc_second};
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg    <= st_next;
            commit_reg <= upd_commit;
        end
    end

    // Result ports.
    assign out_valid  = out_vld_reg;
    assign in_setting = res_reg.setting;
    assign field_sel  = res_reg.field;
    assign set_year   = res_reg.vals.year;
    assign set_month  = res_reg.vals.month;
    assign set_day    = res_reg.vals.day;
    assign set_hour   = res_reg.vals.hour;
    assign set_minute = res_reg.vals.minute;
    assign set_second = res_reg.vals.second;
    assign commit     = commit_reg;

    // A commit always leaves setting mode.
    a_commit_exits: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && commit_reg |-> !res_reg.setting)
        else $error("commit result still shows setting mode");

    // A commit is only given on the last field.
    a_commit_field: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && commit_reg |-> res_reg.field == FIELD_SECOND)
        else $error("commit on a field other than the second");

    // A commit can only come from setting mode.
    a_commit_src: assert property (@(posedge clk) disable iff (!rst_n)
        advance && upd_commit |-> st_reg.setting)
        else $error("commit raised outside setting mode");

    // The selected field never leaves the field list.
    a_field_range: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.field <= FIELD_SECOND)
        else $error("field index out of range");

    // The controller state only changes when a request is processed.
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(st_reg))
        else $error("controller state changed without a request");

endmodule : knob_time_setting_controller_top
